// ===== hdl/alp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alp_pkg
// types, constants and helpers shared by the linked list pool unit
// ----------------------------------------------------------------------------
package alp_pkg;

    localparam int POOL_NODES = 16;
    localparam int IDX_W      = $clog2(POOL_NODES);
    localparam int NODE_W     = 5;
    localparam int WORD_W     = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 88;

    localparam logic [NODE_W-1:0] NIL = '1;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_DELETE = 2'd1;
    localparam kind_t KIND_READ   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BAD_PRED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD2,
        S_WR1,
        S_WR2,
        S_OUT
    } seq_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] grade;
        logic [NODE_W-1:0] link;
    } node_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        node_t            wr_data;
    } ram_req_t;

    typedef struct packed {
        status_t           status;
        logic [NODE_W-1:0] slot;
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] free_head;
        logic              list_empty;
        logic              pool_full;
        logic [WORD_W-1:0] read_id;
        logic [WORD_W-1:0] read_grade;
        logic [NODE_W-1:0] read_next;
    } result_t;

    // node contents right after reset: free chain in index order
    function automatic node_t init_node(input logic [IDX_W-1:0] addr);
        node_t n;
        n.id    = '1;
        n.grade = '1;
        if (addr == IDX_W'(POOL_NODES - 1)) begin
            n.link = NIL;
        end else begin
            n.link = NODE_W'(addr) + NODE_W'(1);
        end
        return n;
    endfunction

    function automatic logic in_pool(input logic [NODE_W-1:0] v);
        return !v[NODE_W-1] && ({1'b0, v} < (NODE_W + 1)'(POOL_NODES));
    endfunction

    function automatic logic pred_ok(input logic [NODE_W-1:0] v);
        return (v == NIL) || in_pool(v);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/alp_node_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alp_node_ram
// node store, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module alp_node_ram
    import alp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire ram_req_t req,
    output node_t         rd_node
);

    node_t              node_mem [POOL_NODES];
    logic [POOL_NODES-1:0] valid_reg;
    node_t              rd_data_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            node_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= node_mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    // entries never written read back as their reset contents
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_node = rd_valid_reg ? rd_data_reg : init_node(rd_addr_reg);

endmodule
`default_nettype wire

// ===== hdl/alp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alp_seq
// operation sequencer: list and free heads, node reads and write-backs
// ----------------------------------------------------------------------------
module alp_seq
    import alp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire kind_t             in_kind,
    input  wire logic [NODE_W-1:0] in_pred,
    input  wire logic [WORD_W-1:0] in_id,
    input  wire logic [WORD_W-1:0] in_grade,
    input  wire node_t             rd_node,
    input  wire logic              out_take,
    output logic                   ready,
    output logic                   res_valid,
    output result_t                res,
    output ram_req_t               ram_req
);

    seq_state_t        state_reg, state_next;
    kind_t             kind_reg, kind_next;
    logic [NODE_W-1:0] pred_reg, pred_next;
    logic [WORD_W-1:0] eid_reg, eid_next;
    logic [WORD_W-1:0] egr_reg, egr_next;
    logic [NODE_W-1:0] head_reg, head_next;
    logic [NODE_W-1:0] free_reg, free_next;
    logic [NODE_W-1:0] slot_reg, slot_next;
    status_t           status_reg, status_next;
    node_t             w1_reg, w1_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= NIL;
            free_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        pred_reg   <= pred_next;
        eid_reg    <= eid_next;
        egr_reg    <= egr_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        w1_reg     <= w1_next;
    end

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        pred_next   = pred_reg;
        eid_next    = eid_reg;
        egr_next    = egr_reg;
        head_next   = head_reg;
        free_next   = free_reg;
        slot_next   = slot_reg;
        status_next = status_reg;
        w1_next     = w1_reg;
        ram_req     = '0;
        ready       = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                ready = 1'b1;
                if (start) begin
                    kind_next   = in_kind;
                    pred_next   = in_pred;
                    eid_next    = in_id;
                    egr_next    = in_grade;
                    slot_next   = NIL;
                    status_next = ST_OK;
                    state_next  = S_OUT;
                    case (in_kind)
                        KIND_INSERT: begin
                            if (!in_pool(free_reg)) begin
                                status_next = ST_FULL;
                            end else if (!pred_ok(in_pred)) begin
                                status_next = ST_BAD_PRED;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = free_reg[IDX_W-1:0];
                                state_next      = S_RD2;
                            end
                        end
                        KIND_DELETE: begin
                            if (!in_pool(head_reg)) begin
                                status_next = ST_EMPTY;
                            end else if (!pred_ok(in_pred)) begin
                                status_next = ST_BAD_PRED;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = (in_pred == NIL) ? head_reg[IDX_W-1:0]
                                                                   : in_pred[IDX_W-1:0];
                                state_next      = S_RD2;
                            end
                        end
                        KIND_READ: begin
                            if (!in_pool(in_pred)) begin
                                status_next = ST_BAD_PRED;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = in_pred[IDX_W-1:0];
                                state_next      = S_RD2;
                            end
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RD2: begin
                w1_next    = rd_node;
                state_next = S_OUT;
                case (kind_reg)
                    KIND_INSERT: begin
                        if (pred_reg == NIL) begin
                            ram_req.wr_en         = 1'b1;
                            ram_req.wr_addr       = free_reg[IDX_W-1:0];
                            ram_req.wr_data.id    = eid_reg;
                            ram_req.wr_data.grade = egr_reg;
                            ram_req.wr_data.link  = head_reg;
                            head_next             = free_reg;
                            free_next             = rd_node.link;
                            slot_next             = free_reg;
                        end else begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = pred_reg[IDX_W-1:0];
                            state_next      = S_WR1;
                        end
                    end
                    KIND_DELETE: begin
                        if (pred_reg == NIL) begin
                            ram_req.wr_en         = 1'b1;
                            ram_req.wr_addr       = head_reg[IDX_W-1:0];
                            ram_req.wr_data.id    = '1;
                            ram_req.wr_data.grade = '1;
                            ram_req.wr_data.link  = free_reg;
                            head_next             = rd_node.link;
                            free_next             = head_reg;
                            slot_next             = head_reg;
                        end else if (!in_pool(rd_node.link)) begin
                            status_next = ST_BAD_PRED;
                        end else begin
                            slot_next       = rd_node.link;
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = rd_node.link[IDX_W-1:0];
                            state_next      = S_WR1;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_WR1: begin
                ram_req.wr_en = 1'b1;
                state_next    = S_WR2;
                if (kind_reg == KIND_INSERT) begin
                    // new node takes over the predecessor's link
                    ram_req.wr_addr       = free_reg[IDX_W-1:0];
                    ram_req.wr_data.id    = eid_reg;
                    ram_req.wr_data.grade = egr_reg;
                    ram_req.wr_data.link  = rd_node.link;
                end else begin
                    // predecessor skips the removed node
                    ram_req.wr_addr       = pred_reg[IDX_W-1:0];
                    ram_req.wr_data.id    = w1_reg.id;
                    ram_req.wr_data.grade = w1_reg.grade;
                    ram_req.wr_data.link  = rd_node.link;
                end
            end

            S_WR2: begin
                ram_req.wr_en = 1'b1;
                state_next    = S_OUT;
                if (kind_reg == KIND_INSERT) begin
                    ram_req.wr_addr = pred_reg[IDX_W-1:0];
                    if (pred_reg == free_reg) begin
                        // predecessor is the node just filled
                        ram_req.wr_data.id    = eid_reg;
                        ram_req.wr_data.grade = egr_reg;
                    end else begin
                        ram_req.wr_data.id    = rd_node.id;
                        ram_req.wr_data.grade = rd_node.grade;
                    end
                    ram_req.wr_data.link = free_reg;
                    free_next            = w1_reg.link;
                    slot_next            = free_reg;
                end else begin
                    ram_req.wr_addr       = slot_reg[IDX_W-1:0];
                    ram_req.wr_data.id    = '1;
                    ram_req.wr_data.grade = '1;
                    ram_req.wr_data.link  = free_reg;
                    free_next             = slot_reg;
                end
            end

            S_OUT: begin
                res_valid = 1'b1;
                if (out_take) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status     = status_reg;
        res.slot       = slot_reg;
        res.head       = head_reg;
        res.free_head  = free_reg;
        res.list_empty = (head_reg == NIL);
        res.pool_full  = (free_reg == NIL);
        if ((kind_reg == KIND_READ) && (status_reg == ST_OK)) begin
            res.read_id    = w1_reg.id;
            res.read_grade = w1_reg.grade;
            res.read_next  = w1_reg.link;
        end else begin
            res.read_id    = '0;
            res.read_grade = '0;
            res.read_next  = NIL;
        end
    end

    // reads and write-backs are serialized, never in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_req.rd_en && ram_req.wr_en))
        else $error("node ram read and write in one cycle");

    a_heads_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pred_ok(head_reg) && pred_ok(free_reg))
        else $error("list or free head outside the pool");

    a_err_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) && (status_reg != ST_OK) |-> (slot_reg == NIL))
        else $error("failed operation reports a slot");

    a_write_only_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.wr_en |-> $past(ram_req.rd_en) || $past(state_reg == S_WR1))
        else $error("write-back without a preceding read");

endmodule
`default_nettype wire

// ===== hdl/array_linked_list_pool_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// from accept to m_tvalid: beats rejected on entry and unused kinds skip the node ram,
// reads and a delete whose predecessor has no successor make one node read, head
// insert/delete one read and one write-back, insert or delete after a predecessor two
// reads and two write-backs, in turn, as the node ram has one read and one write port
// a new beat is taken only once the result has moved to the output register, where it waits
// reset: list empty, all nodes free in index order, no clearing pass needed
// ----------------------------------------------------------------------------
// array_linked_list_pool_unit
// singly linked list over a fixed node pool with a free chain
// ----------------------------------------------------------------------------
module array_linked_list_pool_unit
    import alp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input beat
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pred_index[4:0], entry_id[36:5], entry_grade[68:37], zero pad [71:69]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  wire logic [1:0]           s_tuser,
    // result beat
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // status[1:0], slot[6:2], head[11:7], free_head[16:12], list_empty[17],
    // pool_full[18], read_id[50:19], read_grade[82:51], read_next[87:83]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    ram_req_t ram_req;
    node_t    rd_node;
    result_t  res;
    logic     res_valid;
    logic     seq_ready;
    logic     out_take;
    logic     start;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // sequencer takes a beat only when idle
    assign s_tready = seq_ready;
    assign start    = s_tvalid && seq_ready;

    // output register loads when empty or being drained this cycle
    assign out_take = res_valid && (!m_tvalid_reg || m_tready);

    alp_node_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_node (rd_node)
    );

    alp_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .in_kind   (s_tuser),
        .in_pred   (s_tdata[4:0]),
        .in_id     (s_tdata[36:5]),
        .in_grade  (s_tdata[68:37]),
        .rd_node   (rd_node),
        .out_take  (out_take),
        .ready     (seq_ready),
        .res_valid (res_valid),
        .res       (res),
        .ram_req   (ram_req)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // pack result fields, lowest field first
    always_ff @(posedge aclk) begin
        if (out_take) begin
            m_tdata_reg <= {res.read_next, res.read_grade, res.read_id,
                            res.pool_full, res.list_empty, res.free_head,
                            res.head, res.slot, res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a result is never dropped: the sequencer holds it until the register frees up
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_take |-> !m_tvalid_reg || m_tready)
        else $error("result register overwritten while held");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !res_valid)
        else $error("beat taken while a result is pending in the sequencer");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_take |=> m_tvalid)
        else $error("loaded result not shown");

endmodule
`default_nettype wire

// ===== bench/tb_array_linked_list_pool_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_pool_unit
// self-checking bench for the linked list pool: a planner walks its own copy
// of the pool to build mostly well-formed insert/delete/read traffic, a driver
// and a receiver add random idle bursts, and a monitor predicts every result
// from the accepted input beats and checks each result beat field by field
// ----------------------------------------------------------------------------
module tb_array_linked_list_pool_unit;
    import alp_pkg::*;

    localparam kind_t KIND_UNUSED  = 2'd3;   // no operation, state only reported
    localparam int    TOTAL_ITEMS  = 850;
    localparam int    SETTLE_AT    = 560;    // planned beat that waits for an empty pipe
    localparam int    HOLD_AT      = 300;    // result count that starts the long back-pressure
    localparam int    HOLD_CYCLES  = 80;
    localparam int    QUIET_TAIL   = 100;    // last beats run without idling
    localparam int    TAIL_CYCLES  = 10;     // run on after the last result to catch extra beats
    localparam int    STALL_LIMIT  = 2000;

    // one request as planned and as seen on the input channel
    typedef struct packed {
        kind_t             kind;
        logic [NODE_W-1:0] pred;
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] grade;
        logic              settle;   // hold this beat back until all results are in
    } pool_op_t;

    // whole node pool plus the two chain heads
    typedef struct packed {
        logic [POOL_NODES-1:0][WORD_W-1:0] id;
        logic [POOL_NODES-1:0][WORD_W-1:0] grade;
        logic [POOL_NODES-1:0][NODE_W-1:0] link;
        logic [NODE_W-1:0]                 head;
        logic [NODE_W-1:0]                 free_head;
    } pool_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic                 s_beat_taken = 1'b0;   // input handshake seen at the last rising edge

    pool_op_t pending_ops[$];        // beats still to be offered
    result_t  pending_results[$];    // predicted results, oldest first
    pool_t    plan_pool;             // pool as the planner expects it
    pool_t    live_pool;             // pool as predicted from accepted beats

    int planned_beats = 0;
    int beats_in      = 0;
    int beats_out     = 0;
    int quiet_cycles  = 0;
    int fail_count    = 0;

    // sender and receiver idling
    int send_gap       = 0;
    int send_gap_pct   = 0;
    int send_mode_left = 0;
    int rcv_gap        = 0;
    int rcv_gap_pct    = 0;
    int rcv_mode_left  = 0;
    int hold_left      = HOLD_CYCLES;

    array_linked_list_pool_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // pool behavior
    // ------------------------------------------------------------------------

    // true for an index that addresses a node, false for nil and out of range
    function automatic bit is_node(input logic [NODE_W-1:0] v);
        int sv;
        sv = int'($signed(v));
        return sv >= 0 && sv < POOL_NODES;
    endfunction

    function automatic pool_t pool_after_reset();
        pool_t st;
        for (int i = 0; i < POOL_NODES; i++) begin
            st.id[i]    = '1;
            st.grade[i] = '1;
            st.link[i]  = (i == POOL_NODES - 1) ? NIL : NODE_W'(i + 1);
        end
        st.head      = NIL;
        st.free_head = '0;
        return st;
    endfunction

    // applies one request to a pool and gives the result beat it produces
    function automatic void pool_step(input pool_t st_in, input pool_op_t op,
                                      output pool_t st_out, output result_t r);
        pool_t             st;
        logic [NODE_W-1:0] t;
        logic [IDX_W-1:0]  ti;
        logic [IDX_W-1:0]  pi;
        bit                pred_usable;
        st          = st_in;
        t           = NIL;
        ti          = '0;
        pi          = op.pred[IDX_W-1:0];
        pred_usable = (op.pred == NIL) || is_node(op.pred);
        r.status     = ST_OK;
        r.slot       = NIL;
        r.read_id    = '0;
        r.read_grade = '0;
        r.read_next  = NIL;
        case (op.kind)
            KIND_INSERT: begin
                // exhausted pool wins over a bad predecessor
                if (!is_node(st.free_head)) begin
                    r.status = ST_FULL;
                end else if (!pred_usable) begin
                    r.status = ST_BAD_PRED;
                end else begin
                    t            = st.free_head;
                    ti           = t[IDX_W-1:0];
                    st.free_head = st.link[ti];
                    st.id[ti]    = op.id;
                    st.grade[ti] = op.grade;
                    if (op.pred == NIL) begin
                        st.link[ti] = st.head;
                        st.head     = t;
                    end else begin
                        // predecessor is trusted, even when it is off the list
                        st.link[ti] = st.link[pi];
                        st.link[pi] = t;
                    end
                    r.slot = t;
                end
            end
            KIND_DELETE: begin
                if (!is_node(st.head)) begin
                    r.status = ST_EMPTY;
                end else if (!pred_usable) begin
                    r.status = ST_BAD_PRED;
                end else begin
                    t = (op.pred == NIL) ? st.head : st.link[pi];
                    if (!is_node(t)) begin
                        // predecessor is the tail: nothing to unlink
                        r.status = ST_BAD_PRED;
                    end else begin
                        ti = t[IDX_W-1:0];
                        if (op.pred == NIL) begin
                            st.head = st.link[ti];
                        end else begin
                            st.link[pi] = st.link[ti];
                        end
                        // released node goes to the front of the free chain
                        st.link[ti]  = st.free_head;
                        st.id[ti]    = '1;
                        st.grade[ti] = '1;
                        st.free_head = t;
                        r.slot       = t;
                    end
                end
            end
            KIND_READ: begin
                if (!is_node(op.pred)) begin
                    r.status = ST_BAD_PRED;
                end else begin
                    r.read_id    = st.id[pi];
                    r.read_grade = st.grade[pi];
                    r.read_next  = st.link[pi];
                end
            end
            default: begin
            end
        endcase
        r.head       = st.head;
        r.free_head  = st.free_head;
        r.list_empty = (st.head == NIL);
        r.pool_full  = (st.free_head == NIL);
        st_out       = st;
    endfunction

    // ------------------------------------------------------------------------
    // planning helpers
    // ------------------------------------------------------------------------

    // random node currently on the planned list, nil when the list is empty
    function automatic logic [NODE_W-1:0] pick_member();
        logic [NODE_W-1:0] members [POOL_NODES];
        logic [NODE_W-1:0] at;
        int                n;
        n  = 0;
        at = plan_pool.head;
        // bounded walk, a broken list may loop
        while (is_node(at) && n < POOL_NODES) begin
            members[n] = at;
            n++;
            at = plan_pool.link[at[IDX_W-1:0]];
        end
        if (n == 0) begin
            return NIL;
        end
        return members[$urandom_range(n - 1)];
    endfunction

    // data word with extra weight on the corner values
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    task automatic plan_op(input kind_t k, input logic [NODE_W-1:0] p,
                           input logic [WORD_W-1:0] i, input logic [WORD_W-1:0] g,
                           input logic settle);
        pool_op_t op;
        result_t  r;
        op.kind   = k;
        op.pred   = p;
        op.id     = i;
        op.grade  = g;
        op.settle = settle;
        pending_ops.push_back(op);
        pool_step(plan_pool, op, plan_pool, r);
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                               input logic [WORD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                      beats_out, name, got, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // input driver: changes on the falling edge, valid held until taken
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : sender
        pool_op_t op;
        if (send_mode_left == 0) begin
            send_gap_pct   = pick_idle_pct();
            send_mode_left = $urandom_range(200, 40);
        end else begin
            send_mode_left--;
        end
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_beat_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_ops[0].settle && pending_results.size() != 0) begin
                // pause until the block has handed back every result
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > QUIET_TAIL &&
                         $urandom_range(99) < send_gap_pct) begin
                // idle burst that starts with this cycle
                send_gap = $urandom_range(5, 0);
                s_tvalid <= 1'b0;
            end else begin
                op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= op.kind;
                s_tdata  <= {3'b000, op.grade, op.id, op.pred};
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: random ready bursts plus one long hold-off
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        if (rcv_mode_left == 0) begin
            rcv_gap_pct   = pick_idle_pct();
            rcv_mode_left = $urandom_range(200, 40);
        end else begin
            rcv_mode_left--;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (beats_out >= HOLD_AT && hold_left > 0) begin
            // long back-pressure so the block fills up and drops s_tready
            hold_left--;
            m_tready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            m_tready <= 1'b0;
        end else if (beats_out < planned_beats - QUIET_TAIL &&
                     $urandom_range(99) < rcv_gap_pct) begin
            rcv_gap = $urandom_range(5, 0);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predicts on each input beat, checks each result beat
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        pool_op_t op;
        result_t  want;
        result_t  got;
        if (!aresetn) begin
            s_beat_taken <= 1'b0;
        end else begin
            s_beat_taken <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            // results first, so a beat accepted at this edge can never match
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with nothing expected",
                                              beats_out));
                end else begin
                    want           = pending_results.pop_front();
                    got.status     = status_t'(m_tdata[1:0]);
                    got.slot       = m_tdata[6:2];
                    got.head       = m_tdata[11:7];
                    got.free_head  = m_tdata[16:12];
                    got.list_empty = m_tdata[17];
                    got.pool_full  = m_tdata[18];
                    got.read_id    = m_tdata[50:19];
                    got.read_grade = m_tdata[82:51];
                    got.read_next  = m_tdata[87:83];
                    check_field("status", got.status, want.status);
                    check_field("slot", got.slot, want.slot);
                    check_field("head", got.head, want.head);
                    check_field("free_head", got.free_head, want.free_head);
                    check_field("list_empty", got.list_empty, want.list_empty);
                    check_field("pool_full", got.pool_full, want.pool_full);
                    check_field("read_id", got.read_id, want.read_id);
                    check_field("read_grade", got.read_grade, want.read_grade);
                    check_field("read_next", got.read_next, want.read_next);
                end
                beats_out++;
            end
            if (s_tvalid && s_tready) begin
                op.kind   = s_tuser;
                op.pred   = s_tdata[4:0];
                op.id     = s_tdata[36:5];
                op.grade  = s_tdata[68:37];
                op.settle = 1'b0;
                pool_step(live_pool, op, live_pool, want);
                pending_results.push_back(want);
                beats_in++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : run_control
        int                r;
        int                directed_count;
        bit                filling;
        logic              settle;
        kind_t             k;
        logic [NODE_W-1:0] p;

        plan_pool = pool_after_reset();
        live_pool = pool_after_reset();

        // untouched node, then reads outside the pool
        plan_op(KIND_READ, 5'd0, '0, '0, 1'b0);
        plan_op(KIND_READ, NIL, '1, '1, 1'b0);
        plan_op(KIND_READ, 5'b10000, '0, '0, 1'b0);
        // delete on an empty list, then the unused kind
        plan_op(KIND_DELETE, NIL, '0, '0, 1'b0);
        plan_op(KIND_UNUSED, 5'($urandom), pick_word(), pick_word(), 1'b0);
        // fill the pool: list ends up 15..3, 1, 0, 2 with node 2 as tail
        for (int n = 0; n < POOL_NODES; n++) begin
            if (n == 0) begin
                plan_op(KIND_INSERT, NIL, 32'h8000_0000, 32'h0000_0000, 1'b0);
            end else if (n == 1) begin
                plan_op(KIND_INSERT, NIL, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
            end else if (n == 2) begin
                plan_op(KIND_INSERT, 5'd0, $urandom, $urandom, 1'b0);
            end else begin
                plan_op(KIND_INSERT, NIL, $urandom, $urandom, 1'b0);
            end
        end
        // full pool, also when the predecessor is bad
        plan_op(KIND_INSERT, NIL, $urandom, $urandom, 1'b0);
        plan_op(KIND_INSERT, 5'b10101, $urandom, $urandom, 1'b0);
        // tail as predecessor, and a predecessor below nil
        plan_op(KIND_DELETE, 5'd2, '0, '0, 1'b0);
        plan_op(KIND_DELETE, 5'b11011, '0, '0, 1'b0);
        // head delete, then unlink node 0 after node 1
        plan_op(KIND_DELETE, NIL, '0, '0, 1'b0);
        plan_op(KIND_DELETE, 5'd1, '0, '0, 1'b0);
        // insert after a free node that is not on the list
        plan_op(KIND_INSERT, 5'd15, pick_word(), pick_word(), 1'b0);
        directed_count = pending_ops.size();

        // random part: swing between filling and draining the pool
        filling = 1'b1;
        while (pending_ops.size() < TOTAL_ITEMS) begin
            settle = (pending_ops.size() == directed_count) ||
                     (pending_ops.size() == SETTLE_AT);
            if (plan_pool.head == NIL) begin
                filling = 1'b1;
            end else if (plan_pool.free_head == NIL) begin
                filling = 1'b0;
            end
            r = $urandom_range(99);
            if (r < 3) begin
                // raw noise: any kind, any index, off-list predecessors too
                plan_op(kind_t'($urandom_range(3)), 5'($urandom), pick_word(), pick_word(),
                        settle);
            end else if (r < 7) begin
                k = ($urandom_range(1) == 0) ? KIND_INSERT : KIND_DELETE;
                plan_op(k, 5'(-int'($urandom_range(16, 2))), pick_word(), pick_word(), settle);
            end else if (r < 10) begin
                plan_op(KIND_READ, 5'($urandom), pick_word(), pick_word(), settle);
            end else if (r < 22) begin
                p = ($urandom_range(1) == 0) ? pick_member()
                                             : NODE_W'($urandom_range(POOL_NODES - 1));
                plan_op(KIND_READ, p, pick_word(), pick_word(), settle);
            end else begin
                k = (($urandom_range(99) < 75) == filling) ? KIND_INSERT : KIND_DELETE;
                p = ($urandom_range(99) < 35) ? NIL : pick_member();
                plan_op(k, p, pick_word(), pick_word(), settle);
            end
        end
        planned_beats = pending_ops.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while ((beats_in != planned_beats || pending_results.size() != 0) &&
               quiet_cycles < STALL_LIMIT) begin
            @(negedge aclk);
        end
        // late or extra result beats get caught here
        if (quiet_cycles < STALL_LIMIT) begin
            repeat (TAIL_CYCLES) @(negedge aclk);
        end
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat accepted for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
        end else if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
